[design/scc_pkg.sv]
// Package for the scanline coverage span clipper.
// Holds sizing constants and opcodes shared by the top level and the testbench.
// No dependencies.
package scc_pkg;

  localparam int ROW_COUNT     = 480;
  localparam int SPANS_PER_ROW = 32;
  localparam int ROW_WIDTH     = 640;

  // Field widths fixed by the interface.
  localparam int PX_W  = 10;
  localparam int ROW_W = 9;

  localparam int IDX_W      = $clog2(SPANS_PER_ROW);
  localparam int CNT_W      = $clog2(SPANS_PER_ROW + 1);
  localparam int SPAN_DEPTH = ROW_COUNT * SPANS_PER_ROW;
  localparam int SADDR_W    = $clog2(SPAN_DEPTH);
  localparam int CADDR_W    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int SPAN_DW    = 2 * PX_W;

  // Request opcodes.
  localparam logic OP_CLIP  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

endpackage

[design/scc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old data on a same-cycle write. No dependencies.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/scanline_coverage_span_clipper_unit.sv]
// Top level of the scanline coverage span clipper: request sequencer, piece
// output stage and the span and count memories. Depends on scc_pkg, scc_ram.
//
//   channel | signals                                        | direction
//   in      | in_valid_i/in_ready_o, opcode, span, row       | request beats
//   out     | out_valid_o/out_ready_i, vis_*, last, row_full | visible pieces
//
// A clip request reads the row count in ST_COUNT, then walks the stored
// spans in ST_SCAN up to the merge or insert point plus the shifted tail,
// then writes the new count in ST_FLUSH. The walk is bound by the single
// span memory port walking the row list.
// Reset and a new-frame request sweep the count memory, one row per cycle,
// with in_ready_o low. Sentinels are implied, not stored.
// A full output register stalls the walk only when a second piece is ready.
module scanline_coverage_span_clipper_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [scc_pkg::PX_W-1:0]  span_left_i,
  input  logic [scc_pkg::PX_W-1:0]  span_right_i,
  input  logic [scc_pkg::ROW_W-1:0] row_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [scc_pkg::PX_W-1:0]  vis_left_o,
  output logic [scc_pkg::PX_W-1:0]  vis_right_o,
  output logic [scc_pkg::ROW_W-1:0] vis_row_o,
  output logic                      last_piece_o,
  output logic                      row_full_o
);
  import scc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_COUNT, ST_SCAN, ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    M_BEFORE, M_MERGE, M_AFTER
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  logic [CADDR_W-1:0] clr_q, clr_d;
  logic [PX_W-1:0]    left_q, left_d, right_q, right_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [SADDR_W-1:0] base_q, base_d;
  logic [CNT_W-1:0]   n_q, n_d, n_new_q, n_new_d;
  logic [IDX_W-1:0]   k_q, k_d, p_q, p_d, wr_idx_q, wr_idx_d;
  logic [PX_W-1:0]    acc_l_q, acc_l_d, acc_r_q, acc_r_d;
  logic [PX_W:0]      pos_q, pos_d;
  logic [SPAN_DW-1:0] hold_q, hold_d;

  logic              pend_valid_q, pend_valid_d, pend_full_q, pend_full_d;
  logic [PX_W-1:0]   pend_l_q, pend_l_d, pend_r_q, pend_r_d;
  logic              out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic              out_full_q, out_full_d;
  logic [PX_W-1:0]   out_l_q, out_l_d, out_r_q, out_r_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;

  // Memory ports.
  logic               sp_we, sp_re;
  logic [IDX_W-1:0]   sp_widx, sp_ridx;
  logic [SPAN_DW-1:0] sp_wdata, sp_rdata;
  logic               cnt_we, cnt_re;
  logic [CADDR_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;

  scc_ram #(.WIDTH(SPAN_DW), .DEPTH(SPAN_DEPTH)) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (base_q + SADDR_W'(sp_widx)),
    .wdata_i (sp_wdata),
    .re_i    (sp_re),
    .raddr_i (base_q + SADDR_W'(sp_ridx)),
    .rdata_o (sp_rdata)
  );

  scc_ram #(.WIDTH(CNT_W), .DEPTH(ROW_COUNT)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // Current stored span and its relation to the request.
  logic [PX_W-1:0] sp_l, sp_r;
  logic [PX_W:0]   sp_l_x, sp_r_x, left_x, right_x, acc_r_x;
  logic            at_end, below, above, covered, touch, row_is_full;

  assign sp_l    = sp_rdata[SPAN_DW-1:PX_W];
  assign sp_r    = sp_rdata[PX_W-1:0];
  assign sp_l_x  = {1'b0, sp_l};
  assign sp_r_x  = {1'b0, sp_r};
  assign left_x  = {1'b0, left_q};
  assign right_x = {1'b0, right_q};
  assign acc_r_x = {1'b0, acc_r_q};

  assign at_end      = (CNT_W'(k_q) == n_q - CNT_W'(1));
  assign below       = (sp_r_x + 1'b1) < left_x;
  assign above       = sp_l_x > (right_x + 1'b1);
  assign covered     = (sp_l <= left_q) && (sp_r >= right_q);
  assign touch       = sp_l_x <= (acc_r_x + 1'b1);
  assign row_is_full = (n_q == CNT_W'(SPANS_PER_ROW));

  // Visible piece found this cycle.
  logic            emit_v, emit_full;
  logic [PX_W-1:0] emit_l, emit_r;

  always_comb begin
    emit_v    = 1'b0;
    emit_full = 1'b0;
    emit_l    = left_q;
    emit_r    = right_q;
    if (state_q == ST_SCAN) begin
      unique case (mode_q)
        M_BEFORE: begin
          if (at_end || (!below && above)) begin
            emit_v    = 1'b1;
            emit_full = row_is_full;
          end else if (!below && !covered && (sp_l > left_q)) begin
            emit_v = 1'b1;
            emit_r = sp_l - 1'b1;
          end
        end
        M_MERGE: begin
          emit_l = pos_q[PX_W-1:0];
          if (at_end || !touch) begin
            emit_v = (pos_q <= right_x);
          end else begin
            emit_v = 1'b1;
            emit_r = sp_l - 1'b1;
          end
        end
        default: begin
          emit_v = 1'b0;
        end
      endcase
    end
  end

  logic out_free, stall;
  logic [PX_W-1:0] right_c;

  assign out_free   = !out_valid_q || out_ready_i;
  assign stall      = emit_v && pend_valid_q && !out_free;
  assign in_ready_o = (state_q == ST_IDLE);
  assign right_c    = (32'(span_right_i) >= ROW_WIDTH) ? PX_W'(ROW_WIDTH - 1) : span_right_i;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    clr_d        = clr_q;
    left_d       = left_q;
    right_d      = right_q;
    row_d        = row_q;
    base_d       = base_q;
    n_d          = n_q;
    n_new_d      = n_new_q;
    k_d          = k_q;
    p_d          = p_q;
    wr_idx_d     = wr_idx_q;
    acc_l_d      = acc_l_q;
    acc_r_d      = acc_r_q;
    pos_d        = pos_q;
    hold_d       = hold_q;
    pend_valid_d = pend_valid_q;
    pend_full_d  = pend_full_q;
    pend_l_d     = pend_l_q;
    pend_r_d     = pend_r_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_last_d   = out_last_q;
    out_full_d   = out_full_q;
    out_l_d      = out_l_q;
    out_r_d      = out_r_q;
    out_row_d    = out_row_q;

    sp_we     = 1'b0;
    sp_widx   = k_q;
    sp_wdata  = {left_q, right_q};
    sp_re     = 1'b0;
    sp_ridx   = k_q + 1'b1;
    cnt_we    = 1'b0;
    cnt_waddr = clr_q;
    cnt_wdata = CNT_W'(2);
    cnt_re    = 1'b0;
    cnt_raddr = CADDR_W'(row_i);

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        if (clr_q == CADDR_W'(ROW_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_FRAME) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else if (32'(row_i) < ROW_COUNT && 32'(span_left_i) < ROW_WIDTH
                       && span_left_i <= right_c) begin
            left_d  = span_left_i;
            right_d = right_c;
            row_d   = row_i;
            base_d  = SADDR_W'(row_i) * SADDR_W'(SPANS_PER_ROW);
            cnt_re  = 1'b1;
            state_d = ST_COUNT;
          end
        end
      end

      ST_COUNT: begin
        if (cnt_rdata < CNT_W'(2) || cnt_rdata > CNT_W'(SPANS_PER_ROW)) begin
          n_d = CNT_W'(2);
        end else begin
          n_d = cnt_rdata;
        end
        n_new_d = n_d;
        k_d     = IDX_W'(1);
        sp_ridx = IDX_W'(1);
        sp_re   = 1'b1;
        mode_d  = M_BEFORE;
        state_d = ST_SCAN;
      end

      ST_SCAN: begin
        if (!stall) begin
          if (emit_v) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b0;
              out_full_d  = pend_full_q;
              out_l_d     = pend_l_q;
              out_r_d     = pend_r_q;
              out_row_d   = row_q;
            end
            pend_valid_d = 1'b1;
            pend_full_d  = emit_full;
            pend_l_d     = emit_l;
            pend_r_d     = emit_r;
          end
          unique case (mode_q)
            M_BEFORE: begin
              if (at_end) begin
                if (!row_is_full) begin
                  sp_we   = 1'b1;
                  n_new_d = n_q + 1'b1;
                end
                state_d = ST_FLUSH;
              end else if (below) begin
                sp_re = 1'b1;
                k_d   = k_q + 1'b1;
              end else if (above) begin
                if (row_is_full) begin
                  state_d = ST_FLUSH;
                end else begin
                  sp_we    = 1'b1;
                  n_new_d  = n_q + 1'b1;
                  hold_d   = sp_rdata;
                  wr_idx_d = k_q + 1'b1;
                  mode_d   = M_AFTER;
                  sp_re    = 1'b1;
                  k_d      = k_q + 1'b1;
                end
              end else if (covered) begin
                state_d = ST_FLUSH;
              end else begin
                acc_l_d = (sp_l < left_q) ? sp_l : left_q;
                acc_r_d = (sp_r > right_q) ? sp_r : right_q;
                pos_d   = sp_r_x + 1'b1;
                p_d     = k_q;
                mode_d  = M_MERGE;
                sp_re   = 1'b1;
                k_d     = k_q + 1'b1;
              end
            end
            M_MERGE: begin
              if (!at_end && touch) begin
                if (sp_r > acc_r_q) begin
                  acc_r_d = sp_r;
                end
                pos_d   = sp_r_x + 1'b1;
                n_new_d = n_new_q - 1'b1;
                sp_re   = 1'b1;
                k_d     = k_q + 1'b1;
              end else begin
                // The grown span goes back at its own slot.
                sp_we    = 1'b1;
                sp_widx  = p_q;
                sp_wdata = {acc_l_q, acc_r_q};
                if (at_end || n_new_q == n_q) begin
                  state_d = ST_FLUSH;
                end else begin
                  hold_d   = sp_rdata;
                  wr_idx_d = p_q + 1'b1;
                  mode_d   = M_AFTER;
                  sp_re    = 1'b1;
                  k_d      = k_q + 1'b1;
                end
              end
            end
            default: begin
              // Shifting the tail: write the held span, hold the one just read.
              sp_we    = 1'b1;
              sp_widx  = wr_idx_q;
              sp_wdata = hold_q;
              if (at_end) begin
                state_d = ST_FLUSH;
              end else begin
                wr_idx_d = wr_idx_q + 1'b1;
                hold_d   = sp_rdata;
                sp_re    = 1'b1;
                k_d      = k_q + 1'b1;
              end
            end
          endcase
        end
      end

      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d  = 1'b1;
            out_last_d   = 1'b1;
            out_full_d   = pend_full_q;
            out_l_d      = pend_l_q;
            out_r_d      = pend_r_q;
            out_row_d    = row_q;
            pend_valid_d = 1'b0;
          end
          cnt_we    = 1'b1;
          cnt_waddr = CADDR_W'(row_q);
          cnt_wdata = n_new_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      mode_q       <= M_BEFORE;
      clr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      clr_q        <= clr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    right_q    <= right_d;
    row_q      <= row_d;
    base_q     <= base_d;
    n_q        <= n_d;
    n_new_q    <= n_new_d;
    k_q        <= k_d;
    p_q        <= p_d;
    wr_idx_q   <= wr_idx_d;
    acc_l_q    <= acc_l_d;
    acc_r_q    <= acc_r_d;
    pos_q      <= pos_d;
    hold_q     <= hold_d;
    pend_full_q <= pend_full_d;
    pend_l_q   <= pend_l_d;
    pend_r_q   <= pend_r_d;
    out_last_q <= out_last_d;
    out_full_q <= out_full_d;
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
    out_row_q  <= out_row_d;
  end

  assign out_valid_o  = out_valid_q;
  assign vis_left_o   = out_l_q;
  assign vis_right_o  = out_r_q;
  assign vis_row_o    = out_row_q;
  assign last_piece_o = out_last_q;
  assign row_full_o   = out_full_q;

endmodule

[dv/tb_scanline_coverage_span_clipper_unit.sv]
`timescale 1ns / 100ps
// Testbench for scanline_coverage_span_clipper_unit: directed table plus random
// clip and new-frame requests, checked against a behavioral span-list predictor.
// Depends on scc_pkg and the top level of the span clipper.
module tb_scanline_coverage_span_clipper_unit;
  import scc_pkg::*;

  localparam int   SENT_LO  = -5;
  localparam int   SENT_HI  = 1000;
  localparam int   STALL_LIMIT = 5000;
  localparam int   HOLD_CYCLES = 300;

  typedef struct packed {
    logic [PX_W-1:0]  l;
    logic [PX_W-1:0]  r;
    logic [ROW_W-1:0] row;
    logic             last;
    logic             full;
  } piece_t;

  typedef struct {
    logic             op;
    logic [PX_W-1:0]  l;
    logic [PX_W-1:0]  r;
    logic [ROW_W-1:0] row;
    bit               typed;
    int               nexp;
    piece_t           ex;
  } stim_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             opcode_i = OP_CLIP;
  logic [PX_W-1:0]  span_left_i = '0;
  logic [PX_W-1:0]  span_right_i = '0;
  logic [ROW_W-1:0] row_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [PX_W-1:0]  vis_left_o;
  logic [PX_W-1:0]  vis_right_o;
  logic [ROW_W-1:0] vis_row_o;
  logic             last_piece_o;
  logic             row_full_o;

  scanline_coverage_span_clipper_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Covered spans per row, sentinels included.
  int     cov_l [ROW_COUNT][SPANS_PER_ROW];
  int     cov_r [ROW_COUNT][SPANS_PER_ROW];
  int     cov_n [ROW_COUNT];
  piece_t new_pieces[$];
  piece_t pending_pieces[$];
  stim_t  dir_tbl[$];

  int  err_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;

  function automatic void clear_coverage();
    for (int y = 0; y < ROW_COUNT; y++) begin
      cov_l[y][0] = SENT_LO; cov_r[y][0] = SENT_LO;
      cov_l[y][1] = SENT_HI; cov_r[y][1] = SENT_HI;
      cov_n[y] = 2;
    end
  endfunction

  function automatic void add_piece(int a, int b, int y, bit full);
    piece_t pc;
    pc.l = a[PX_W-1:0];
    pc.r = b[PX_W-1:0];
    pc.row = y[ROW_W-1:0];
    pc.last = 1'b0;
    pc.full = full;
    new_pieces.push_back(pc);
  endfunction

  // Computes the visible pieces of one request and merges it into the row list; a new-frame request clears every row.
  function automatic void clip_span(logic op, int left, int right, int y);
    int  n, i, p, m, removed;
    bit  full;
    new_pieces.delete();
    if (op == OP_FRAME) begin
      clear_coverage();
      return;
    end
    if (y >= ROW_COUNT || left >= ROW_WIDTH) return;
    if (right > ROW_WIDTH - 1) right = ROW_WIDTH - 1;
    if (left > right) return;
    n = cov_n[y];
    i = 0;
    while (i + 1 < n - 1 && cov_l[y][i+1] <= left) i++;
    if (cov_r[y][i] >= left - 1) begin
      if (right <= cov_r[y][i]) return;
      p = i;
    end else if (right >= cov_l[y][i+1] - 1) begin
      add_piece(left, cov_l[y][i+1] - 1, y, 1'b0);
      p = i + 1;
    end else begin
      full = (n >= SPANS_PER_ROW);
      add_piece(left, right, y, full);
      if (!full) begin
        for (int j = n; j > i + 1; j--) begin
          cov_l[y][j] = cov_l[y][j-1];
          cov_r[y][j] = cov_r[y][j-1];
        end
        cov_l[y][i+1] = left;
        cov_r[y][i+1] = right;
        cov_n[y] = n + 1;
      end
      new_pieces[$].last = 1'b1;
      return;
    end
    m = p + 1;
    while (m < n && right >= cov_l[y][m] - 1) begin
      if (cov_r[y][m] > right) right = cov_r[y][m];
      add_piece(cov_r[y][m-1] + 1, cov_l[y][m] - 1, y, 1'b0);
      m++;
    end
    if (cov_r[y][m-1] + 1 <= right) add_piece(cov_r[y][m-1] + 1, right, y, 1'b0);
    if (left < cov_l[y][p]) cov_l[y][p] = left;
    if (right > cov_r[y][p]) cov_r[y][p] = right;
    removed = m - (p + 1);
    if (removed > 0) begin
      for (int j = m; j < n; j++) begin
        cov_l[y][j-removed] = cov_l[y][j];
        cov_r[y][j-removed] = cov_r[y][j];
      end
    end
    cov_n[y] = n - removed;
    if (new_pieces.size() > 0) new_pieces[$].last = 1'b1;
  endfunction

  // Offers one request beat, waits for acceptance, then records its pieces.
  task automatic send_item(stim_t s);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= s.op;
    span_left_i  <= s.l;
    span_right_i <= s.r;
    row_i        <= s.row;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    clip_span(s.op, int'(s.l), int'(s.r), int'(s.row));
    if (s.typed) begin
      if (s.nexp > 0) pending_pieces.push_back(s.ex);
    end else begin
      foreach (new_pieces[k]) pending_pieces.push_back(new_pieces[k]);
    end
  endtask

  task automatic send_clip(int l, int r, int y);
    stim_t s;
    s = '{OP_CLIP, l[PX_W-1:0], r[PX_W-1:0], y[ROW_W-1:0], 1'b0, 0, '0};
    send_item(s);
  endtask

  // Output checker and receiver stall generator.
  always @(posedge clk_i) begin
    piece_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = '{vis_left_o, vis_right_o, vis_row_o, last_piece_o, row_full_o};
      if (pending_pieces.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected piece %p", got);
      end else begin
        want = pending_pieces.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) $display("piece mismatch: expected %p, actual %p", want, got);
        end
      end
    end
    if (hold_req) begin
      hold_cnt = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb_scanline_coverage_span_clipper_unit: errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic random_phase(int items);
    int sel, y, l, w, cnt;
    stim_t s;
    cnt = 0;
    while (cnt < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        s = '{OP_FRAME, PX_W'($urandom), PX_W'($urandom), ROW_W'($urandom), 1'b0, 0, '0};
        send_item(s);
        cnt++;
      end else if (sel < 8) begin
        s = '{OP_CLIP, PX_W'($urandom), PX_W'($urandom), ROW_W'($urandom), 1'b0, 0, '0};
        send_item(s);
        cnt++;
      end else if (sel < 11) begin
        // Dense burst of narrow spans that fills one row list, then a wide cover.
        y = $urandom_range(0, ROW_COUNT - 1);
        for (int k = 0; k < 34; k++) begin
          l = k * 18 + $urandom_range(0, 3);
          send_clip(l, l + $urandom_range(0, 9), y);
        end
        send_clip($urandom_range(0, 20), $urandom_range(600, 1023), y);
        cnt += 35;
      end else begin
        y = $urandom_range(0, 7);
        l = $urandom_range(0, ROW_WIDTH - 1);
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 700) : $urandom_range(0, 40);
        send_clip(l, l + w, y);
        cnt++;
      end
    end
  endtask

  initial begin
    clear_coverage();
    // Fresh rows, empty and out-of-range requests, saturation, merges, new frame.
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd0,   1, 1, '{10'd0, 10'd639, 9'd0, 1, 0}});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd0,   1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd10,   10'd5,    9'd1,   1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd480, 1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd511, 1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd640,  10'd1023, 9'd2,   1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd1023, 10'd1023, 9'd2,   1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd600,  10'd1023, 9'd479, 1, 1, '{10'd600, 10'd639, 9'd479, 1, 0}});
    dir_tbl.push_back('{OP_CLIP, 10'd100,  10'd200,  9'd3,   1, 1, '{10'd100, 10'd200, 9'd3, 1, 0}});
    dir_tbl.push_back('{OP_CLIP, 10'd300,  10'd400,  9'd3,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd150,  10'd350,  9'd3,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd401,  10'd401,  9'd3,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd0,    9'd3,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd2,    10'd639,  9'd3,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd639,  10'd639,  9'd4,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd637,  10'd637,  9'd4,   0, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd4,   0, 0, '0});
    dir_tbl.push_back('{OP_FRAME, 10'd0,   10'd0,    9'd0,   1, 0, '0});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd0,   1, 1, '{10'd0, 10'd639, 9'd0, 1, 0}});
    dir_tbl.push_back('{OP_CLIP, 10'd0,    10'd639,  9'd3,   1, 1, '{10'd0, 10'd639, 9'd3, 1, 0}});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 49;
    foreach (dir_tbl[k]) send_item(dir_tbl[k]);
    random_phase(130);
    send_idle_pct = 49;
    recv_idle_pct = 28;
    random_phase(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while requests keep coming.
    hold_req = 1'b1;
    random_phase(150);

    in_valid_i <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_scanline_coverage_span_clipper_unit: clean");
    end else begin
      $display("tb_scanline_coverage_span_clipper_unit: errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/scc_pkg.sv
design/scc_ram.sv
design/scanline_coverage_span_clipper_unit.sv
dv/tb_scanline_coverage_span_clipper_unit.sv
